[hw/rtl/abvc_pkg.sv]
package abvc_pkg;

  // Pipeline control that travels with each item
  typedef struct packed {
    logic valid;
    logic deg;
  } abvc_ctl_t;

  // Angle accumulator: Q30 radians, signed with headroom for CORDIC overshoot
  localparam int Z_W   = 35;
  localparam int XY_W  = 64;
  localparam int Z_FRAC = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int PRESCALE_SH  = 28;
  localparam int SQRT_STEPS   = 32;

  localparam logic signed [Z_W-1:0] PI_Z      = 35'sd3373259426;
  localparam logic signed [Z_W-1:0] HALF_PI_Z = 35'sd1686629713;

  // atan(2^-i) in Q30, truncated
  function automatic logic signed [Z_W-1:0] atan_at(input int unsigned i);
    logic signed [Z_W-1:0] t;
    case (i)
      0: t = 35'sh03243F6A8;
      1: t = 35'sh01DAC6705;
      2: t = 35'sh00FADBAFC;
      3: t = 35'sh007F56EA6;
      4: t = 35'sh003FEAB76;
      5: t = 35'sh001FFD55B;
      6: t = 35'sh000FFFAAA;
      7: t = 35'sh0007FFF55;
      8: t = 35'sh0003FFFEA;
      9: t = 35'sh0001FFFFD;
      default: t = (35'sd1 <<< (Z_FRAC - i)) - 35'sd1;
    endcase
    return t;
  endfunction

  // Right shift that truncates the magnitude toward zero
  function automatic logic signed [XY_W-1:0] tshr(input logic signed [XY_W-1:0] v,
                                                  input int unsigned i);
    logic [XY_W-1:0] m;
    logic signed [XY_W-1:0] r;
    if (v < 0) begin
      m = -v;
      r = -$signed(m >> i);
    end else begin
      r = v >>> i;
    end
    return r;
  endfunction

endpackage

[hw/rtl/abvc_isqrt.sv]
// Pipelined integer square root, one result bit per stage
module abvc_isqrt
  import abvc_pkg::*;
#(
  parameter int SIDE_W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  abvc_ctl_t         ctl_in,
  input  logic [63:0]       n_in,
  input  logic [SIDE_W-1:0] side_in,
  output abvc_ctl_t         ctl_out,
  output logic [31:0]       root,
  output logic [SIDE_W-1:0] side_out
);

  logic [63:0]       n_r    [0:SQRT_STEPS-1];
  logic [63:0]       res_r  [0:SQRT_STEPS-1];
  logic [SIDE_W-1:0] side_r [0:SQRT_STEPS-1];
  abvc_ctl_t         ctl_r  [0:SQRT_STEPS-1];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0]       n_cur, res_cur, n_nxt, res_nxt, trial;
    logic [SIDE_W-1:0] side_cur;
    abvc_ctl_t         ctl_cur;

    if (k == 0) begin : g_first
      assign n_cur    = n_in;
      assign res_cur  = 64'd0;
      assign side_cur = side_in;
      assign ctl_cur  = ctl_in;
    end else begin : g_rest
      assign n_cur    = n_r[k-1];
      assign res_cur  = res_r[k-1];
      assign side_cur = side_r[k-1];
      assign ctl_cur  = ctl_r[k-1];
    end

    // try the next root bit
    always_comb begin
      trial = res_cur + BIT;
      if (n_cur >= trial) begin
        n_nxt   = n_cur - trial;
        res_nxt = (res_cur >> 1) + BIT;
      end else begin
        n_nxt   = n_cur;
        res_nxt = res_cur >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else if (en) begin
        ctl_r[k] <= ctl_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k]    <= n_nxt;
        res_r[k]  <= res_nxt;
        side_r[k] <= side_cur;
      end
    end
  end

  assign ctl_out  = ctl_r[SQRT_STEPS-1];
  assign root     = res_r[SQRT_STEPS-1][31:0];
  assign side_out = side_r[SQRT_STEPS-1];

endmodule

[hw/rtl/abvc_cordic.sv]
// Pipelined vectoring CORDIC: angle of (dot, |cross|), one rotation per stage
module abvc_cordic
  import abvc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  abvc_ctl_t             ctl_in,
  input  logic [31:0]           cross_len,
  input  logic                  dot_neg,
  input  logic [30:0]           dot_mag,
  output abvc_ctl_t             ctl_out,
  output logic signed [Z_W-1:0] z_out
);

  logic signed [XY_W-1:0] x_r [0:CORDIC_STEPS];
  logic signed [XY_W-1:0] y_r [0:CORDIC_STEPS];
  logic signed [Z_W-1:0]  z_r [0:CORDIC_STEPS];
  abvc_ctl_t              ctl_r [0:CORDIC_STEPS];

  // start point, rotated by a quarter turn when the dot product is negative
  logic signed [XY_W-1:0] x0_nxt, y0_nxt;
  logic signed [Z_W-1:0]  z0_nxt;

  always_comb begin
    if (dot_neg) begin
      x0_nxt = $signed(XY_W'(cross_len)) <<< PRESCALE_SH;
      y0_nxt = $signed(XY_W'(dot_mag)) <<< PRESCALE_SH;
      z0_nxt = HALF_PI_Z;
    end else begin
      x0_nxt = $signed(XY_W'(dot_mag)) <<< PRESCALE_SH;
      y0_nxt = $signed(XY_W'(cross_len)) <<< PRESCALE_SH;
      z0_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= x0_nxt;
      y_r[0] <= y0_nxt;
      z_r[0] <= z0_nxt;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    localparam logic signed [Z_W-1:0] T = atan_at(i);
    logic signed [XY_W-1:0] x_nxt, y_nxt;
    logic signed [Z_W-1:0]  z_nxt;

    // drive y toward zero
    always_comb begin
      if (y_r[i] >= 0) begin
        x_nxt = x_r[i] + tshr(y_r[i], i);
        y_nxt = y_r[i] - tshr(x_r[i], i);
        z_nxt = z_r[i] + T;
      end else begin
        x_nxt = x_r[i] - tshr(y_r[i], i);
        y_nxt = y_r[i] + tshr(x_r[i], i);
        z_nxt = z_r[i] - T;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[i+1] <= '0;
      end else if (en) begin
        ctl_r[i+1] <= ctl_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1] <= x_nxt;
        y_r[i+1] <= y_nxt;
        z_r[i+1] <= z_nxt;
      end
    end
  end

  assign ctl_out = ctl_r[CORDIC_STEPS];
  assign z_out   = z_r[CORDIC_STEPS];

endmodule

[hw/rtl/angle_between_vectors_at_center_unit.sv]
// Angle at a center point between two 3D points. Each item carries the first
// point, the second point and the center as signed Q15.16 coordinates; the
// result is the angle in unsigned Q2.16 radians (0 to pi) with a degenerate
// flag when either vector from the center has zero length (angle then 0).
// The datapath is a pipeline that takes one item every cycle unless the output
// stalls: 7 front stages for differences, scaling, cross and dot products and
// sum of squares, 32 square-root stages, 31 CORDIC stages and one output
// stage. A stall on the output holds the whole pipeline; in_tready follows
// out_tready while the output register is full.
module angle_between_vectors_at_center_unit
  import abvc_pkg::*;
#(
  parameter int COORD_WIDTH     = 32,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z,
  // center_x, center_y, center_z (COORD_WIDTH bits each), zero pad
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // angle (ANGLE_FRAC_BITS+2 bits), zero pad
  output logic [((ANGLE_FRAC_BITS+2+7)/8)*8-1:0] out_tdata,
  // degenerate
  output logic out_tuser
);

  localparam int CW    = COORD_WIDTH;
  localparam int MW    = (CW > 30) ? CW : 30;
  localparam int AW    = ANGLE_FRAC_BITS + 2;
  localparam int OUT_W = ((AW + 7) / 8) * 8;

  function automatic logic [6:0] bitlen(input logic [63:0] v);
    logic [6:0] n;
    n = '0;
    for (int b = 0; b < 64; b++) begin
      if (v[b]) n = 7'(b + 1);
    end
    return n;
  endfunction

  logic en;
  logic out_tvalid_r;
  logic [AW-1:0] angle_r;
  logic deg_out_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // ---- stage 1: vectors from the center, sign/magnitude ----
  logic [2:0][MW-1:0] am_nxt, bm_nxt, am_r, bm_r;
  logic [2:0]         as_nxt, bs_nxt, as_r, bs_r;
  logic               deg1_nxt;
  abvc_ctl_t          ctl1_r;

  always_comb begin
    logic signed [CW:0] c, fa, fb, da, db;
    logic [CW:0] ma, mb;
    logic za, zb;
    za = 1'b1;
    zb = 1'b1;
    for (int k = 0; k < 3; k++) begin
      c  = $signed({in_tdata[(6+k)*CW + CW-1], in_tdata[(6+k)*CW +: CW]});
      fa = $signed({in_tdata[k*CW + CW-1], in_tdata[k*CW +: CW]});
      fb = $signed({in_tdata[(3+k)*CW + CW-1], in_tdata[(3+k)*CW +: CW]});
      da = fa - c;
      db = fb - c;
      ma = da[CW] ? (~da + 1'b1) : da;
      mb = db[CW] ? (~db + 1'b1) : db;
      am_nxt[k] = MW'(ma[CW-1:0]);
      bm_nxt[k] = MW'(mb[CW-1:0]);
      as_nxt[k] = da[CW];
      bs_nxt[k] = db[CW];
      if (da != '0) za = 1'b0;
      if (db != '0) zb = 1'b0;
    end
    deg1_nxt = za || zb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else if (en) begin
      ctl1_r <= '{valid: in_tvalid, deg: deg1_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am_r <= am_nxt;
      bm_r <= bm_nxt;
      as_r <= as_nxt;
      bs_r <= bs_nxt;
    end
  end

  // ---- stage 2: scale each vector below 2^30 ----
  logic [2:0][29:0] a_nxt, b_nxt, a_r, b_r;
  logic [2:0]       as2_r, bs2_r;
  abvc_ctl_t        ctl2_r;

  always_comb begin
    logic [MW-1:0] ora, orb;
    logic [6:0] la, lb, sa, sb;
    logic [MW-1:0] ta, tb;
    ora = '0;
    orb = '0;
    for (int k = 0; k < 3; k++) begin
      ora = ora | am_r[k];
      orb = orb | bm_r[k];
    end
    la = bitlen(64'(ora));
    lb = bitlen(64'(orb));
    sa = (la > 7'd30) ? la - 7'd30 : 7'd0;
    sb = (lb > 7'd30) ? lb - 7'd30 : 7'd0;
    for (int k = 0; k < 3; k++) begin
      ta = am_r[k] >> sa;
      tb = bm_r[k] >> sb;
      a_nxt[k] = ta[29:0];
      b_nxt[k] = tb[29:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else if (en) begin
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      as2_r <= as_r;
      bs2_r <= bs_r;
    end
  end

  // ---- stage 3: the nine component products ----
  // order: a1b2 a2b1 a2b0 a0b2 a0b1 a1b0 a0b0 a1b1 a2b2
  logic [8:0][60:0] p_nxt, p_r;
  abvc_ctl_t        ctl3_r;

  always_comb begin
    int ia [9];
    int ib [9];
    logic [59:0] m;
    logic [60:0] e;
    ia = '{1, 2, 2, 0, 0, 1, 0, 1, 2};
    ib = '{2, 1, 0, 2, 1, 0, 0, 1, 2};
    for (int j = 0; j < 9; j++) begin
      m = 60'(a_r[ia[j]]) * 60'(b_r[ib[j]]);
      e = {1'b0, m};
      p_nxt[j] = (as2_r[ia[j]] ^ bs2_r[ib[j]]) ? (~e + 61'd1) : e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r <= '0;
    end else if (en) begin
      ctl3_r <= ctl2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) p_r <= p_nxt;
  end

  // ---- stage 4: cross product and dot product ----
  logic signed [63:0] w_nxt [4];
  logic signed [63:0] w_r   [4];
  abvc_ctl_t          ctl4_r;

  always_comb begin
    logic signed [63:0] q [9];
    for (int j = 0; j < 9; j++) q[j] = 64'($signed(p_r[j]));
    w_nxt[0] = q[0] - q[1];
    w_nxt[1] = q[2] - q[3];
    w_nxt[2] = q[4] - q[5];
    w_nxt[3] = q[6] + q[7] + q[8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl4_r <= '0;
    end else if (en) begin
      ctl4_r <= ctl3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) w_r <= w_nxt;
  end

  // ---- stage 5: common scale of cross and dot below 2^31 ----
  logic [2:0][30:0] cm_nxt, cm_r;
  logic [30:0]      dm_nxt, dm5_r;
  logic             dn5_r;
  abvc_ctl_t        ctl5_r;

  always_comb begin
    logic [63:0] m [4];
    logic [63:0] orw, t;
    logic [6:0] l, s;
    orw = '0;
    for (int j = 0; j < 4; j++) begin
      m[j] = (w_r[j] < 0) ? 64'(-w_r[j]) : 64'(w_r[j]);
      orw  = orw | m[j];
    end
    l = bitlen(orw);
    s = (l > 7'd31) ? l - 7'd31 : 7'd0;
    for (int j = 0; j < 3; j++) begin
      t = m[j] >> s;
      cm_nxt[j] = t[30:0];
    end
    t = m[3] >> s;
    dm_nxt = t[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl5_r <= '0;
    end else if (en) begin
      ctl5_r <= ctl4_r;
    end
  end

  // a dot product scaled down to zero counts as non-negative
  always_ff @(posedge clk) begin
    if (en) begin
      cm_r  <= cm_nxt;
      dm5_r <= dm_nxt;
      dn5_r <= (w_r[3] < 0) && (dm_nxt != '0);
    end
  end

  // ---- stage 6: squares of the cross components ----
  logic [2:0][61:0] sq_r;
  logic [30:0]      dm6_r;
  logic             dn6_r;
  abvc_ctl_t        ctl6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl6_r <= '0;
    end else if (en) begin
      ctl6_r <= ctl5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) sq_r[j] <= 62'(cm_r[j]) * 62'(cm_r[j]);
      dm6_r <= dm5_r;
      dn6_r <= dn5_r;
    end
  end

  // ---- stage 7: sum of squares ----
  logic [63:0] sum_r;
  logic [30:0] dm7_r;
  logic        dn7_r;
  abvc_ctl_t   ctl7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl7_r <= '0;
    end else if (en) begin
      ctl7_r <= ctl6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= 64'(sq_r[0]) + 64'(sq_r[1]) + 64'(sq_r[2]);
      dm7_r <= dm6_r;
      dn7_r <= dn6_r;
    end
  end

  // ---- cross length ----
  abvc_ctl_t   ctl_sq;
  logic [31:0] cross_len;
  logic [31:0] dot_sq;

  abvc_isqrt #(.SIDE_W(32)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .ctl_in   (ctl7_r),
    .n_in     (sum_r),
    .side_in  ({dn7_r, dm7_r}),
    .ctl_out  (ctl_sq),
    .root     (cross_len),
    .side_out (dot_sq)
  );

  // ---- angle ----
  abvc_ctl_t             ctl_cd;
  logic signed [Z_W-1:0] z_cd;

  abvc_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ctl_in    (ctl_sq),
    .cross_len (cross_len),
    .dot_neg   (dot_sq[31]),
    .dot_mag   (dot_sq[30:0]),
    .ctl_out   (ctl_cd),
    .z_out     (z_cd)
  );

  // ---- output: clamp to [0, pi] and round ----
  logic [31:0]   zc;
  logic [AW-1:0] ang;

  always_comb begin
    if (z_cd < 0) begin
      zc = '0;
    end else if (z_cd > PI_Z) begin
      zc = PI_Z[31:0];
    end else begin
      zc = z_cd[31:0];
    end
  end

  if (ANGLE_FRAC_BITS >= Z_FRAC) begin : g_noround
    assign ang = AW'(zc);
  end else begin : g_round
    logic [35:0] rs;
    assign rs  = ({4'b0, zc} + (36'd1 << (Z_FRAC - 1 - ANGLE_FRAC_BITS)))
                 >> (Z_FRAC - ANGLE_FRAC_BITS);
    assign ang = rs[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= ctl_cd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r   <= ctl_cd.deg ? '0 : ang;
      deg_out_r <= ctl_cd.deg;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'(angle_r);
  assign out_tuser  = deg_out_r;

endmodule

[dv/angle_between_vectors_at_center_unit_test.sv]
`timescale 1ns / 100ps

module angle_between_vectors_at_center_unit_test;
  import abvc_pkg::*;

  localparam int CW = 32;
  localparam int AFB = 16;
  localparam int IN_W = ((9 * CW + 7) / 8) * 8;
  localparam int OUT_W = ((AFB + 2 + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 1630;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 150;

  localparam longint Q30_PI = 64'sd3373259426;
  localparam longint Q30_HALF_PI = 64'sd1686629713;

  typedef struct {
    logic [AFB+1:0] angle;
    logic           degenerate;
  } angle_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic out_tuser;

  logic [IN_W-1:0] point_sets[$];
  angle_res_t angles_due[$];
  int mismatches = 0;
  int cycles = 0;

  angle_between_vectors_at_center_unit #(
    .COORD_WIDTH(CW),
    .ANGLE_FRAC_BITS(AFB)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // magnitude shift toward zero
  function automatic longint trunc_shift(longint v, int s);
    if (v < 0) return -((-v) >>> s);
    return v >>> s;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic int scale_shift(longint unsigned m, longint unsigned lim);
    int s;
    s = 0;
    while ((m >> s) >= lim) s++;
    return s;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint atan_q30(int i);
    longint head[10];
    head = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
             64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD};
    if (i < 10) return head[i];
    return (64'sd1 <<< (30 - i)) - 1;
  endfunction

  // angle at center for one packed point set
  function automatic angle_res_t center_angle(logic [IN_W-1:0] d);
    angle_res_t r;
    longint va[3], vb[3], w[4];
    longint cen, x, y, z, nx, ny;
    longint unsigned m, sq;
    int s;
    for (int k = 0; k < 3; k++) begin
      cen = longint'($signed(d[(6+k)*CW +: CW]));
      va[k] = longint'($signed(d[k*CW +: CW])) - cen;
      vb[k] = longint'($signed(d[(3+k)*CW +: CW])) - cen;
    end
    if ((va[0] == 0 && va[1] == 0 && va[2] == 0) ||
        (vb[0] == 0 && vb[1] == 0 && vb[2] == 0)) begin
      r.angle = '0;
      r.degenerate = 1'b1;
      return r;
    end
    // bring each vector below 2^30
    m = 0;
    for (int k = 0; k < 3; k++) if (magnitude(va[k]) > m) m = magnitude(va[k]);
    s = scale_shift(m, 64'd1 << 30);
    for (int k = 0; k < 3; k++) va[k] = trunc_shift(va[k], s);
    m = 0;
    for (int k = 0; k < 3; k++) if (magnitude(vb[k]) > m) m = magnitude(vb[k]);
    s = scale_shift(m, 64'd1 << 30);
    for (int k = 0; k < 3; k++) vb[k] = trunc_shift(vb[k], s);
    // cross and dot
    w[0] = va[1] * vb[2] - va[2] * vb[1];
    w[1] = va[2] * vb[0] - va[0] * vb[2];
    w[2] = va[0] * vb[1] - va[1] * vb[0];
    w[3] = va[0] * vb[0] + va[1] * vb[1] + va[2] * vb[2];
    m = 0;
    for (int k = 0; k < 4; k++) if (magnitude(w[k]) > m) m = magnitude(w[k]);
    s = scale_shift(m, 64'd1 << 31);
    for (int k = 0; k < 4; k++) w[k] = trunc_shift(w[k], s);
    sq = magnitude(w[0]) * magnitude(w[0]) + magnitude(w[1]) * magnitude(w[1]) +
         magnitude(w[2]) * magnitude(w[2]);
    y = longint'(floor_sqrt(sq));
    if (w[3] < 0) begin
      x = y;
      y = -w[3];
      z = Q30_HALF_PI;
    end else begin
      x = w[3];
      z = 0;
    end
    x = x <<< 28;
    y = y <<< 28;
    // vectoring CORDIC
    for (int i = 0; i < 30; i++) begin
      if (y >= 0) begin
        nx = x + trunc_shift(y, i);
        ny = y - trunc_shift(x, i);
        z += atan_q30(i);
      end else begin
        nx = x - trunc_shift(y, i);
        ny = y + trunc_shift(x, i);
        z -= atan_q30(i);
      end
      x = nx;
      y = ny;
    end
    if (z < 0) z = 0;
    if (z > Q30_PI) z = Q30_PI;
    z = (z + (64'sd1 <<< (29 - AFB))) >>> (30 - AFB);
    r.angle = z[AFB+1:0];
    r.degenerate = 1'b0;
    return r;
  endfunction

  function automatic logic [IN_W-1:0] point_set(logic [CW-1:0] c[9]);
    logic [IN_W-1:0] d;
    d = '0;
    for (int k = 0; k < 9; k++) d[k*CW +: CW] = c[k];
    return d;
  endfunction

  // random offset of magnitude below 2^k
  function automatic logic [CW-1:0] rand_offset(int k);
    logic [CW-1:0] v;
    v = $urandom & ((32'd1 << k) - 1);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic logic [CW-1:0] pick_extreme();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h00000000;
      3: return 32'h00000001;
      4: return 32'hFFFFFFFF;
      default: return 32'h00010000;
    endcase
  endfunction

  function automatic logic [IN_W-1:0] random_set();
    logic [CW-1:0] c[9];
    logic [CW-1:0] o[3];
    int k, mul;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        for (int j = 0; j < 9; j++) c[j] = $urandom;
      end
      3, 4, 5: begin
        for (int j = 0; j < 3; j++) begin
          c[6+j] = $urandom;
          c[j] = c[6+j] + rand_offset($urandom_range(0, 31));
          c[3+j] = c[6+j] + rand_offset($urandom_range(0, 31));
        end
      end
      6: begin
        // one or both vectors of zero length
        k = $urandom_range(0, 2);
        for (int j = 0; j < 9; j++) c[j] = $urandom;
        for (int j = 0; j < 3; j++) begin
          if (k != 1) c[j] = c[6+j];
          if (k != 0) c[3+j] = c[6+j];
        end
      end
      7: begin
        // parallel or antiparallel
        k = $urandom_range(0, 20);
        mul = $urandom_range(1, 5);
        if ($urandom_range(0, 1)) mul = -mul;
        for (int j = 0; j < 3; j++) begin
          c[6+j] = $urandom;
          o[j] = rand_offset(k);
          c[j] = c[6+j] + o[j];
          c[3+j] = c[6+j] + o[j] * mul;
        end
      end
      8: begin
        for (int j = 0; j < 9; j++) c[j] = pick_extreme();
      end
      default: begin
        // axis-aligned vectors
        for (int j = 0; j < 3; j++) begin
          c[6+j] = $urandom;
          c[j] = c[6+j];
          c[3+j] = c[6+j];
        end
        k = $urandom_range(0, 2);
        c[k] = c[6+k] + rand_offset($urandom_range(1, 31));
        k = $urandom_range(0, 2);
        c[3+k] = c[6+k] + rand_offset($urandom_range(1, 31));
      end
    endcase
    return point_set(c);
  endfunction

  // stimulus
  initial begin
    logic [CW-1:0] c[9];
    c = '{default: 32'h0};
    point_sets.push_back(point_set(c));
    c = '{32'h10000, 0, 0, 0, 0, 0, 0, 0, 0};
    point_sets.push_back(point_set(c));
    c = '{0, 0, 0, 0, 32'h10000, 0, 0, 0, 0};
    point_sets.push_back(point_set(c));
    c = '{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 0};
    point_sets.push_back(point_set(c));
    c = '{32'h10000, 0, 0, 32'h20000, 0, 0, 0, 0, 0};
    point_sets.push_back(point_set(c));
    c = '{32'h10000, 0, 0, 32'hFFFE0000, 0, 0, 0, 0, 0};
    point_sets.push_back(point_set(c));
    c = '{1, 0, 0, 0, 0, 1, 0, 0, 0};
    point_sets.push_back(point_set(c));
    c = '{1, 1, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0};
    point_sets.push_back(point_set(c));
    c = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
          32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000};
    point_sets.push_back(point_set(c));
    c = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
          32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
    point_sets.push_back(point_set(c));
    c = '{32'h7FFFFFFF, 0, 0, 32'h80000000, 0, 0, 0, 0, 0};
    point_sets.push_back(point_set(c));
    c = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
          32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000};
    point_sets.push_back(point_set(c));
    c = '{32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'h12345679, 32'h9ABCDEF0,
          32'h0F0F0F0F, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F};
    point_sets.push_back(point_set(c));
    c = '{32'h10000, 32'h1, 0, 32'h10000, 0, 0, 0, 0, 0};
    point_sets.push_back(point_set(c));
    c = '{32'h10000, 0, 0, 32'hFFFF0000, 32'h1, 0, 0, 0, 0};
    point_sets.push_back(point_set(c));
    c = '{32'h10000, 32'h10000, 0, 32'hFFFF0000, 32'h10000, 0, 0, 0, 0};
    point_sets.push_back(point_set(c));
    c = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
          32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
    point_sets.push_back(point_set(c));
    for (int n = 0; n < RANDOM_ITEMS; n++) point_sets.push_back(random_set());

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    wait (point_sets.size() == 0 && !in_tvalid);
    wait (angles_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && angles_due.size() == 0) begin
      $display("angle_between_vectors_at_center_unit_test OK");
    end else begin
      $display("angle_between_vectors_at_center_unit_test NOT OK");
    end
    $finish;
  end

  // driver: bursts of items with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) angles_due.push_back(center_angle(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (point_sets.size() > 0) begin
          in_tdata <= point_sets.pop_front();
          in_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off to fill the pipeline
  int rx_mode = 0;
  int rx_mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && cycles > 600) begin
        hold_done = 1'b1;
        hold_left = 300;
        out_tready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_mode_left = $urandom_range(20, 200);
        end else begin
          rx_mode_left--;
        end
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 1) == 1);
          2: out_tready <= ($urandom_range(0, 7) != 0);
          default: out_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    angle_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (angles_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: angle %0d degenerate %0b",
                   out_tdata[AFB+1:0], out_tuser);
      end else begin
        want = angles_due.pop_front();
        if (out_tdata[AFB+1:0] !== want.angle || out_tuser !== want.degenerate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: angle exp %0d got %0d, degenerate exp %0b got %0b",
                     want.angle, out_tdata[AFB+1:0], want.degenerate, out_tuser);
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("angle_between_vectors_at_center_unit_test NOT OK");
      $finish;
    end
  end

endmodule
